// File: hdl/rpn_pkg.sv
// ============================================================================
// rpn_pkg
// Shared types, request and status codes for the RPN stack engine.
// ============================================================================
package rpn_pkg;

    localparam int DATA_W            = 32;
    localparam int DEPTH_W           = 7;
    localparam int STACK_DEPTH_DEF   = 64;

    // request codes (req_type field)
    localparam logic [2:0] REQ_PUSH = 3'd0;
    localparam logic [2:0] REQ_ADD  = 3'd1;
    localparam logic [2:0] REQ_SUB  = 3'd2;
    localparam logic [2:0] REQ_MUL  = 3'd3;
    localparam logic [2:0] REQ_PEEK = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOOPS = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] operand_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        logic [1:0]               status;
    } rsp_t;

    // per-cell shift control
    typedef struct packed {
        logic load_above;   // take neighbor nearer the top (push; at cell 0 also an ALU result)
        logic load_below;   // take neighbor farther from the top (pop)
    } cell_ctl_t;

endpackage

// File: hdl/rpn_stack_calculator_top.sv
// ============================================================================
// rpn_stack_calculator_top
// Integer RPN stack engine built as a row of shifting cells, top at cell 0.
// ============================================================================
//
//   channel | signals                        | beat
//   --------+--------------------------------+------------------------------
//   in      | in_valid, in_ready, in_data    | one request (req_t)
//   out     | out_valid, out_ready, out_data | one result per request (rsp_t)
//
// One request per cycle while in_ready is high. An accepted push or
// arithmetic request shifts the whole stack by one cell; the ALU multiply in
// front of cell 0 sets the path. Results show the cycle after their request.
// Reset clears the entry count and the result valid; cell contents stay
// undefined.
// in_ready drops only while a result is held and out_ready is low.
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpn_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rpn_pkg::rsp_t out_data
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    logic [rpn_pkg::DATA_W-1:0] cell_val [STACK_DEPTH];
    rpn_pkg::cell_ctl_t         cell_ctl [STACK_DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    rpn_pkg::rsp_t    rsp_reg, rsp_next;

    logic                       in_fire;
    logic                       push_ok, arith_ok;
    logic [rpn_pkg::DATA_W-1:0] alu_res, head_val, top_next;
    logic [1:0]                 status;
    logic [CNT_W+rpn_pkg::DEPTH_W-1:0] depth_wide;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    rpn_alu u_alu (
        .op     (in_data.req_type),
        .tos    (cell_val[0]),
        .sec    (cell_val[1]),
        .result (alu_res)
    );

    always_comb
    begin
        push_ok  = 1'b0;
        arith_ok = 1'b0;
        status   = rpn_pkg::ST_OK;
        unique case (in_data.req_type) inside
            rpn_pkg::REQ_PUSH:
            begin
                if (count_reg == FULL_CNT)
                begin
                    status = rpn_pkg::ST_OVER;
                end
                else
                begin
                    push_ok = 1'b1;
                end
            end
            rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL:
            begin
                if (count_reg < TWO_CNT)
                begin
                    status = rpn_pkg::ST_NOOPS;
                end
                else
                begin
                    arith_ok = 1'b1;
                end
            end
            rpn_pkg::REQ_PEEK:
            begin
                if (count_reg == '0)
                begin
                    status = rpn_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                status = rpn_pkg::ST_OK;
            end
        endcase
    end

    assign head_val = push_ok ? in_data.operand_value : alu_res;

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (arith_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        if (count_next == '0)
        begin
            top_next = '0;
        end
        else if (push_ok || arith_ok)
        begin
            top_next = head_val;
        end
        else
        begin
            top_next = cell_val[0];
        end
    end

    assign depth_wide = {{rpn_pkg::DEPTH_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next.top_value   = top_next;
        rsp_next.stack_depth = depth_wide[rpn_pkg::DEPTH_W-1:0];
        rsp_next.status      = status;
    end

    // row of cells; cell 0 takes the pushed value or the ALU result
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [rpn_pkg::DATA_W-1:0] above_val, below_val;

        if (i == 0)
        begin : g_head
            assign above_val           = head_val;
            assign cell_ctl[i].load_above = in_fire && (push_ok || arith_ok);
            assign cell_ctl[i].load_below = 1'b0;
        end
        else
        begin : g_body
            assign above_val           = cell_val[i-1];
            assign cell_ctl[i].load_above = in_fire && push_ok;
            assign cell_ctl[i].load_below = in_fire && arith_ok;
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign below_val = '0;
        end
        else
        begin : g_link
            assign below_val = cell_val[i+1];
        end

        rpn_cell u_cell (
            .clk   (clk),
            .ctl   (cell_ctl[i]),
            .above (above_val),
            .below (below_val),
            .value (cell_val[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above stack depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && push_ok |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("push did not grow the stack");

    a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted request gave no result beat");

    a_depth_matches: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> rsp_reg.stack_depth ==
                    $past(depth_wide[rpn_pkg::DEPTH_W-1:0]))
        else $error("reported depth differs from entry count");

    a_over_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && status == rpn_pkg::ST_OVER |-> count_reg == FULL_CNT &&
                                                 !push_ok)
        else $error("overflow status on a stack that is not full");

endmodule

// File: hdl/rpn_cell.sv
// ============================================================================
// rpn_cell
// One stack entry. Loads from the neighbor above on a push, from the
// neighbor below on a pop, otherwise holds.
// ============================================================================
module rpn_cell (
    input  logic                       clk,
    input  rpn_pkg::cell_ctl_t         ctl,
    input  logic [rpn_pkg::DATA_W-1:0] above,
    input  logic [rpn_pkg::DATA_W-1:0] below,
    output logic [rpn_pkg::DATA_W-1:0] value
);

    logic [rpn_pkg::DATA_W-1:0] value_reg;
    logic [rpn_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load_above)
        begin
            value_next = above;
        end
        else if (ctl.load_below)
        begin
            value_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: hdl/rpn_alu.sv
// ============================================================================
// rpn_alu
// Wrapping add, subtract (second minus top) and multiply of the top two
// stack entries.
// ============================================================================
module rpn_alu (
    input  logic [2:0]                 op,
    input  logic [rpn_pkg::DATA_W-1:0] tos,
    input  logic [rpn_pkg::DATA_W-1:0] sec,
    output logic [rpn_pkg::DATA_W-1:0] result
);

    always_comb
    begin
        case (op)
            rpn_pkg::REQ_ADD: result = sec + tos;
            rpn_pkg::REQ_SUB: result = sec - tos;
            rpn_pkg::REQ_MUL: result = sec * tos;
            default:          result = sec + tos;
        endcase
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the RPN stack engine: a shadow stack predicts the
// top value, depth and status of every request, and the scoreboard compares
// each result beat in order. Traffic alternates fill, drain and mixed runs
// so the stack swings between empty and full under random valid/ready pacing.
// ============================================================================

class rpn_scoreboard;

    localparam int CAPACITY = rpn_pkg::STACK_DEPTH_DEF;

    logic [31:0]   shadow_stack [CAPACITY];
    int unsigned   shadow_depth;
    rpn_pkg::rsp_t expected_q [$];
    int            errors;

    function new();
        shadow_depth = 0;
        errors       = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_request(rpn_pkg::req_t r);
        rpn_pkg::rsp_t e;
        logic [31:0]   top_v;
        logic [31:0]   second_v;
        logic [31:0]   combined;
        e.status = rpn_pkg::ST_OK;
        case (r.req_type) inside
            rpn_pkg::REQ_PUSH:
            begin
                if (shadow_depth >= CAPACITY)
                    e.status = rpn_pkg::ST_OVER;
                else
                begin
                    shadow_stack[shadow_depth] = r.operand_value;
                    shadow_depth++;
                end
            end
            rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL:
            begin
                if (shadow_depth < 2)
                    e.status = rpn_pkg::ST_NOOPS;
                else
                begin
                    top_v    = shadow_stack[shadow_depth-1];
                    second_v = shadow_stack[shadow_depth-2];
                    if (r.req_type == rpn_pkg::REQ_ADD)
                        combined = second_v + top_v;
                    else if (r.req_type == rpn_pkg::REQ_SUB)
                        combined = second_v - top_v;
                    else
                        combined = second_v * top_v;
                    shadow_depth--;
                    shadow_stack[shadow_depth-1] = combined;
                end
            end
            rpn_pkg::REQ_PEEK:
            begin
                if (shadow_depth == 0)
                    e.status = rpn_pkg::ST_EMPTY;
            end
            default: ;  // unused codes leave the stack alone
        endcase
        e.top_value   = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth-1];
        e.stack_depth = shadow_depth[6:0];
        expected_q.push_back(e);
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(rpn_pkg::rsp_t got);
        rpn_pkg::rsp_t e;
        if (expected_q.size() == 0)
        begin
            report($sformatf("unexpected result top=%h depth=%0d status=%0d",
                             got.top_value, got.stack_depth, got.status));
            return;
        end
        e = expected_q.pop_front();
        if (got.top_value !== e.top_value)
            report($sformatf("top_value got %h exp %h", got.top_value, e.top_value));
        if (got.stack_depth !== e.stack_depth)
            report($sformatf("stack_depth got %0d exp %0d",
                             got.stack_depth, e.stack_depth));
        if (got.status !== e.status)
            report($sformatf("status got %0d exp %0d", got.status, e.status));
    endtask

endclass

module tb;

    localparam int          NUM_ITEMS      = 1100;
    localparam int          IDLE_LIMIT     = 2000;
    localparam logic [2:0]  REQ_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  REQ_UNUSED_MID = 3'd6;
    localparam logic [2:0]  REQ_UNUSED_HI  = 3'd7;

    typedef enum logic [1:0] {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_mode_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    rpn_pkg::req_t in_data   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    rpn_pkg::rsp_t out_data;

    rpn_scoreboard sb = new();

    int          burst_left  = 0;
    int          idle_cycles = 0;
    int unsigned cyc         = 0;
    int          pace_left   = 0;
    logic [1:0]  pace_mode   = 2'd0;

    rpn_stack_calculator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // receiver pacing: always ready, coin flip, 1 of 4, or 3 of 4
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (pace_left == 0)
        begin
            pace_mode <= 2'($urandom_range(0, 3));
            pace_left <= $urandom_range(16, 96);
        end
        else
            pace_left <= pace_left - 1;
        case (pace_mode)
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (cyc[1:0] == 2'd0);
            default: out_ready <= (cyc[1:0] != 2'd0);
        endcase
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [2:0] code, input logic [31:0] val);
        rpn_pkg::req_t r;
        int            gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        r.req_type      = code;
        r.operand_value = val;
        in_data  <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 2)
            return 32'($signed($urandom_range(0, 15)) - 8);
        if (sel == 2)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'h7FFF_FFFF;
                3: return 32'h8000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_code(seg_mode_t mode);
        int roll;
        int push_pct;
        int arith_pct;
        roll = $urandom_range(0, 99);
        case (mode)
            SEG_FILL:
            begin
                push_pct  = 80;
                arith_pct = 10;
            end
            SEG_DRAIN:
            begin
                push_pct  = 10;
                arith_pct = 80;
            end
            default:
            begin
                push_pct  = 45;
                arith_pct = 40;
            end
        endcase
        if (roll < push_pct)
            return rpn_pkg::REQ_PUSH;
        if (roll < push_pct + arith_pct)
            return 3'($urandom_range(rpn_pkg::REQ_ADD, rpn_pkg::REQ_MUL));
        if (roll < 95)
            return rpn_pkg::REQ_PEEK;
        return 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    endfunction

    initial
    begin
        int          counted;
        int          seg_left;
        seg_mode_t   mode;
        logic [2:0]  code;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-stack corners
        send_request(rpn_pkg::REQ_PEEK, 32'h0000_0000);
        send_request(rpn_pkg::REQ_ADD,  32'h1234_5678);
        send_request(rpn_pkg::REQ_SUB,  32'h0000_0000);
        send_request(rpn_pkg::REQ_MUL,  32'hFFFF_FFFF);
        send_request(REQ_UNUSED_HI,     32'hFFFF_FFFF);
        // single entry: arithmetic refused, top still reported
        send_request(rpn_pkg::REQ_PUSH, 32'h7FFF_FFFF);
        send_request(rpn_pkg::REQ_MUL,  32'h0000_0000);
        // add wraps to most negative
        send_request(rpn_pkg::REQ_PUSH, 32'h0000_0001);
        send_request(rpn_pkg::REQ_ADD,  32'h0000_0000);
        send_request(rpn_pkg::REQ_PUSH, 32'h8000_0000);
        send_request(rpn_pkg::REQ_SUB,  32'h0000_0000);
        // operand order: 5 3 - gives 2
        send_request(rpn_pkg::REQ_PUSH, 32'h0000_0005);
        send_request(rpn_pkg::REQ_PUSH, 32'h0000_0003);
        send_request(rpn_pkg::REQ_SUB,  32'h0000_0000);
        send_request(rpn_pkg::REQ_PUSH, 32'hFFFF_FFFF);
        send_request(rpn_pkg::REQ_MUL,  32'h0000_0000);
        // product overflows 32 bits
        send_request(rpn_pkg::REQ_PUSH, 32'h0001_0000);
        send_request(rpn_pkg::REQ_PUSH, 32'h0001_0000);
        send_request(rpn_pkg::REQ_MUL,  32'h0000_0000);
        send_request(REQ_UNUSED_LO,     32'h5A5A_A5A5);
        send_request(REQ_UNUSED_MID,    32'h0000_0000);
        send_request(rpn_pkg::REQ_PEEK, 32'hFFFF_FFFF);
        send_request(rpn_pkg::REQ_ADD,  32'h0000_0000);

        counted  = 0;
        seg_left = 0;
        mode     = SEG_FILL;
        while (counted < NUM_ITEMS)
        begin
            if (seg_left == 0)
            begin
                mode     = seg_mode_t'($urandom_range(0, 2));
                seg_left = $urandom_range(40, 140);
            end
            seg_left--;
            code = pick_code(mode);
            send_request(code, pick_operand());
            if (code <= rpn_pkg::REQ_PEEK)
                counted++;
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
hdl/rpn_pkg.sv
hdl/rpn_cell.sv
hdl/rpn_alu.sv
hdl/rpn_stack_calculator_top.sv
sim/tb.sv
